FILE: sv/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// shared types and constants for the event timer slot table
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int SLOT_W         = 4;
    localparam int DATA_W         = 32;
    localparam int INDEX_W        = 8;

    // request codes
    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_ADD_SINGLE = 2'd1,
        OP_ADD_REPEAT = 2'd2,
        OP_REMOVE     = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    tick_step;
        logic    scan_next;
        logic    add_write;
        logic    remove_exec;
        logic    result_we;
        logic    result_tick;
        status_t result_status;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic mask_zero;
        logic scan_hit;
        logic scan_last;
        logic sweep_last;
        logic index_bad;
    } stat_t;

endpackage

FILE: sv/event_timer_slot_table.sv
// ----------------------------------------------------------------------------
// event_timer_slot_table
// table of countdown timer slots with add, remove and tick requests
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low. exactly one item
// comes back per request: done is high for one cycle with status, slot and
// fired_events valid, and the receiver has no way to hold it off, so it must
// take the item in that cycle. result ports keep their value until the next
// item. a tick is a sweep that reads one slot per cycle from the count,
// reload and mask memories (one read and one write port each) and writes the
// count back in the next cycle; an add is a scan of the active flags, one
// slot per cycle, stopping at the first free slot; a remove checks the
// index and then clears the slot's flags.
// busy drops in the cycle done rises, so the next request may be issued then.
// period p fires after p+1 ticks; a zero mask or a full table refuses an add
// with status 1, and a remove at or above SLOT_COUNT reports status 2.
// ----------------------------------------------------------------------------
module event_timer_slot_table #(
    parameter int SLOT_COUNT = ets_pkg::SLOT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic [ets_pkg::DATA_W-1:0]   period,
    input  logic [ets_pkg::DATA_W-1:0]   event_mask,
    input  logic [ets_pkg::INDEX_W-1:0]  slot_index,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [ets_pkg::SLOT_W-1:0]   slot,
    output logic [ets_pkg::DATA_W-1:0]   fired_events
);

    // command and status between sequencer and datapath
    ets_pkg::cmd_t  cmd;
    ets_pkg::stat_t stat;

    // sequencer: idle, tick sweep, free slot scan, remove
    ets_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // slot storage, sweep pipeline and result registers
    ets_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .period       (period),
        .event_mask   (event_mask),
        .slot_index   (slot_index),
        .status       (status),
        .slot         (slot),
        .fired_events (fired_events),
        .done         (done)
    );

endmodule

FILE: sv/ets_ctrl.sv
// ----------------------------------------------------------------------------
// ets_ctrl
// request sequencer: tick sweep, free slot scan, remove
// ----------------------------------------------------------------------------
module ets_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    op,
    input  ets_pkg::stat_t stat,
    output ets_pkg::cmd_t  cmd,
    output logic          busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_TICK   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_REMOVE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.result_status = ets_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    unique case (op)
                        ets_pkg::OP_TICK:   state_next = S_TICK;
                        ets_pkg::OP_REMOVE: state_next = S_REMOVE;
                        default:            state_next = S_SCAN;
                    endcase
                end
            end
            S_TICK:
            begin
                cmd.tick_step = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.result_we   = 1'b1;
                    cmd.result_tick = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.mask_zero)
                begin
                    cmd.result_we     = 1'b1;
                    cmd.result_status = ets_pkg::ST_REFUSED;
                    state_next        = S_IDLE;
                end
                else if (stat.scan_hit)
                begin
                    cmd.add_write = 1'b1;
                    cmd.result_we = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.scan_last)
                begin
                    cmd.result_we     = 1'b1;
                    cmd.result_status = ets_pkg::ST_REFUSED;
                    state_next        = S_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_REMOVE:
            begin
                cmd.result_we = 1'b1;
                if (stat.index_bad)
                begin
                    cmd.result_status = ets_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    cmd.remove_exec = 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: sv/ets_dpath.sv
// ----------------------------------------------------------------------------
// ets_dpath
// slot flags, slot memories, sweep index and result registers
// ----------------------------------------------------------------------------
module ets_dpath #(
    parameter int SLOT_COUNT = ets_pkg::SLOT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ets_pkg::cmd_t                cmd,
    output ets_pkg::stat_t               stat,
    input  logic [1:0]                   op,
    input  logic [ets_pkg::DATA_W-1:0]   period,
    input  logic [ets_pkg::DATA_W-1:0]   event_mask,
    input  logic [ets_pkg::INDEX_W-1:0]  slot_index,
    output logic [1:0]                   status,
    output logic [ets_pkg::SLOT_W-1:0]   slot,
    output logic [ets_pkg::DATA_W-1:0]   fired_events,
    output logic                         done
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int DW = ets_pkg::DATA_W;

    // captured request
    logic [1:0]                  op_reg;
    logic [DW-1:0]               period_reg;
    logic [DW-1:0]               mask_reg;
    logic [ets_pkg::INDEX_W-1:0] index_reg;

    // slot flags
    logic [SLOT_COUNT-1:0] active_reg;
    logic [SLOT_COUNT-1:0] active_next;
    logic [SLOT_COUNT-1:0] repeat_reg;
    logic [SLOT_COUNT-1:0] repeat_next;

    // slot memories
    logic [DW-1:0] count_mem  [SLOT_COUNT];
    logic [DW-1:0] reload_mem [SLOT_COUNT];
    logic [DW-1:0] mask_mem   [SLOT_COUNT];
    logic [DW-1:0] rd_count;
    logic [DW-1:0] rd_reload;
    logic [DW-1:0] rd_mask;

    // sweep / scan index and process stage
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [AW-1:0] addr;
    logic          idx_in_range;
    logic          proc_valid_reg;
    logic [AW-1:0] proc_idx_reg;

    // tick processing
    logic          proc_en;
    logic          proc_active;
    logic          proc_fire;
    logic          count_we;
    logic [AW-1:0] count_waddr;
    logic [DW-1:0] count_wdata;
    logic [DW-1:0] fired_reg;
    logic [DW-1:0] fired_next;

    // results
    logic [1:0]                status_reg;
    logic [ets_pkg::SLOT_W-1:0] slot_reg;
    logic [DW-1:0]             events_reg;
    logic                      done_reg;

    assign addr         = idx_reg[AW-1:0];
    assign idx_in_range = (idx_reg < CW'(SLOT_COUNT));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            period_reg <= period;
            mask_reg   <= event_mask;
            index_reg  <= slot_index;
        end
    end

    // index counter
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.capture)
        begin
            idx_next = '0;
        end
        else if ((cmd.tick_step && idx_in_range) || cmd.scan_next)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
        end
        else
        begin
            idx_reg        <= idx_next;
            proc_valid_reg <= cmd.tick_step && idx_in_range;
            proc_idx_reg   <= addr;
        end
    end

    // process stage of the tick sweep
    assign proc_en     = cmd.tick_step && proc_valid_reg;
    assign proc_active = proc_en && active_reg[proc_idx_reg];
    assign proc_fire   = proc_active && (rd_count == '0);
    assign fired_next  = fired_reg | (proc_fire ? rd_mask : '0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fired_reg <= '0;
        end
        else if (proc_en)
        begin
            fired_reg <= fired_next;
        end
    end

    always_comb
    begin
        count_we    = 1'b0;
        count_waddr = proc_idx_reg;
        count_wdata = rd_count - DW'(1);
        if (cmd.add_write)
        begin
            count_we    = 1'b1;
            count_waddr = addr;
            count_wdata = period_reg;
        end
        else if (proc_active)
        begin
            count_we = !proc_fire || repeat_reg[proc_idx_reg];
            if (proc_fire)
            begin
                count_wdata = rd_reload;
            end
        end
    end

    // slot memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (count_we)
        begin
            count_mem[count_waddr] <= count_wdata;
        end
        if (cmd.add_write)
        begin
            reload_mem[addr] <= period_reg;
            mask_mem[addr]   <= mask_reg;
        end
        rd_count  <= count_mem[addr];
        rd_reload <= reload_mem[addr];
        rd_mask   <= mask_mem[addr];
    end

    // flag updates
    always_comb
    begin
        active_next = active_reg;
        repeat_next = repeat_reg;
        if (cmd.add_write)
        begin
            active_next[addr] = 1'b1;
            repeat_next[addr] = (op_reg == ets_pkg::OP_ADD_REPEAT);
        end
        else if (cmd.remove_exec)
        begin
            active_next[index_reg[AW-1:0]] = 1'b0;
            repeat_next[index_reg[AW-1:0]] = 1'b0;
        end
        else if (proc_fire && !repeat_reg[proc_idx_reg])
        begin
            active_next[proc_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            repeat_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            repeat_reg <= repeat_next;
        end
    end

    // status to the controller
    assign stat.mask_zero  = (mask_reg == '0);
    assign stat.scan_hit   = !active_reg[addr];
    assign stat.scan_last  = (idx_reg == CW'(SLOT_COUNT - 1));
    assign stat.sweep_last = proc_valid_reg && (proc_idx_reg == AW'(SLOT_COUNT - 1));
    assign stat.index_bad  = (index_reg >= ets_pkg::INDEX_W'(SLOT_COUNT));

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.result_we)
        begin
            status_reg <= cmd.result_status;
            slot_reg   <= cmd.add_write ? ets_pkg::SLOT_W'(idx_reg) : '0;
            events_reg <= cmd.result_tick ? fired_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.result_we;
        end
    end

    assign status       = status_reg;
    assign slot         = slot_reg;
    assign fired_events = events_reg;
    assign done         = done_reg;

endmodule

FILE: sv/ets_checker.sv
// ----------------------------------------------------------------------------
// ets_checker
// port-level checks for the event timer slot table
// ----------------------------------------------------------------------------
module ets_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [1:0]                   status,
    input logic [ets_pkg::SLOT_W-1:0]   slot,
    input logic [ets_pkg::DATA_W-1:0]   fired_events
);

    // an accepted request always occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // the block only frees up by delivering an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result item");

    // a result is never shown while a request is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result item while busy");

    // refused or bad requests carry no slot and no events
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ets_pkg::ST_OK)) |->
            ((slot == '0) && (fired_events == '0) && (status <= ets_pkg::ST_BAD_INDEX)))
        else $error("error item carries payload");

endmodule

bind event_timer_slot_table ets_checker u_ets_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .fired_events (fired_events)
);
